FILE: rtl/sfm_pkg.sv
package sfm_pkg;

  // default widths
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF    = 24;

  // fixed field widths
  localparam int SUM_BITS   = 32;
  localparam int SUMSQ_BITS = 63;
  localparam int DEV_BITS   = 48;
  localparam int ADDR_BITS  = 3;

  localparam logic [DEV_BITS-1:0] DEV_MAX = '1;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_NEG_VAR  = 2'd2;

  // register index
  localparam logic REG_SAMPLE_MODE = 1'b0;

  // sideband that travels with each request
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } sfm_tag_t;

endpackage

FILE: rtl/stddev_from_moments.sv
// standard deviation from sum, count and sum of squares, unsigned Q32.16 floored
// pipeline: input stages, then a restoring divider and a square root
// (NUM_BITS = COUNT_BITS + 63 + 2*FRACTION_BITS quotient bits, one divider stage
// each; ROOT_BITS = ceil(NUM_BITS/2) square root stages, one root bit each)
// throughput: one request per cycle, busy stays low, results cannot be stalled
// reset clears all stage valid bits and sample_mode
module stddev_from_moments #(
  parameter int FRACTION_BITS = sfm_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_BITS    = sfm_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sfm_pkg::SUM_BITS-1:0] group_sum,
  input  logic [COUNT_BITS-1:0]              group_count,
  input  logic [sfm_pkg::SUMSQ_BITS-1:0]     group_sum_squares,
  output logic                               done,
  output logic [sfm_pkg::DEV_BITS-1:0]       deviation,
  output logic [1:0]                         status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sfm_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int PROD_BITS = COUNT_BITS + sfm_pkg::SUMSQ_BITS;
  localparam int NUM_BITS  = PROD_BITS + 2 * FRACTION_BITS;
  localparam int DEN_BITS  = 2 * COUNT_BITS;
  localparam int ROOT_BITS = (NUM_BITS + 1) / 2;
  localparam int EXT_BITS  = ROOT_BITS + sfm_pkg::DEV_BITS;

  logic sample_mode;
  logic wr_en;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= 1'b0;
    end else if (wr_en && paddr[2] == sfm_pkg::REG_SAMPLE_MODE) begin
      sample_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == sfm_pkg::REG_SAMPLE_MODE) ? {31'b0, sample_mode} : 32'b0;

  assign busy = 1'b0;

  // input decode
  logic [31:0]           mag;
  logic [COUNT_BITS-1:0] divisor;
  logic                  div_zero;

  always_comb begin
    mag      = group_sum[31] ? (~group_sum + 32'd1) : group_sum;
    divisor  = sample_mode ? (group_count - COUNT_BITS'(1)) : group_count;
    div_zero = (group_count == '0) || (divisor == '0);
  end

  // stage 1: partial products
  sfm_pkg::sfm_tag_t     s1_tag;
  logic [COUNT_BITS+31:0] s1_plo;
  logic [COUNT_BITS+30:0] s1_phi;
  logic [63:0]            s1_sq;
  logic [DEN_BITS-1:0]    s1_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= start && !busy;
    end
    s1_tag.status <= div_zero ? sfm_pkg::STATUS_DIV_ZERO : sfm_pkg::STATUS_OK;
    s1_plo <= (COUNT_BITS+32)'(group_count) * (COUNT_BITS+32)'(group_sum_squares[31:0]);
    s1_phi <= (COUNT_BITS+31)'(group_count) * (COUNT_BITS+31)'(group_sum_squares[62:32]);
    s1_sq  <= 64'(mag) * 64'(mag);
    s1_den <= DEN_BITS'(group_count) * DEN_BITS'(divisor);
  end

  // stage 2: n * sum of squares
  sfm_pkg::sfm_tag_t    s2_tag;
  logic [PROD_BITS-1:0] s2_prod;
  logic [63:0]          s2_sq;
  logic [DEN_BITS-1:0]  s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else begin
      s2_tag.valid <= s1_tag.valid;
    end
    s2_tag.status <= s1_tag.status;
    s2_prod <= PROD_BITS'(s1_plo) + (PROD_BITS'(s1_phi) << 32);
    s2_sq   <= s1_sq;
    s2_den  <= s1_den;
  end

  // stage 3: variance numerator, sign check, scaling
  sfm_pkg::sfm_tag_t    s3_tag;
  logic [NUM_BITS-1:0]  s3_num;
  logic [DEN_BITS-1:0]  s3_den;
  logic                 neg;
  logic [PROD_BITS-1:0] diff;

  always_comb begin
    neg  = s2_prod < PROD_BITS'(s2_sq);
    diff = s2_prod - PROD_BITS'(s2_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag.valid <= 1'b0;
    end else begin
      s3_tag.valid <= s2_tag.valid;
    end
    if (s2_tag.status != sfm_pkg::STATUS_OK) begin
      s3_tag.status <= s2_tag.status;
      s3_num        <= '0;
      s3_den        <= DEN_BITS'(1);
    end else if (neg) begin
      s3_tag.status <= sfm_pkg::STATUS_NEG_VAR;
      s3_num        <= '0;
      s3_den        <= DEN_BITS'(1);
    end else begin
      s3_tag.status <= sfm_pkg::STATUS_OK;
      s3_num        <= NUM_BITS'(diff) << (2 * FRACTION_BITS);
      s3_den        <= s2_den;
    end
  end

  // pipelined divider
  sfm_pkg::sfm_tag_t   dv_tag;
  logic [NUM_BITS-1:0] dv_quo;

  sfm_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (DEN_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (s3_tag),
    .in_num  (s3_num),
    .in_den  (s3_den),
    .out_tag (dv_tag),
    .out_quo (dv_quo)
  );

  // pipelined square root
  sfm_pkg::sfm_tag_t    sq_tag;
  logic [ROOT_BITS-1:0] sq_root;

  sfm_sqrt #(
    .ROOT_BITS (ROOT_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (dv_tag),
    .in_val   ((2*ROOT_BITS)'(dv_quo)),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  // saturate and register the result
  logic [EXT_BITS-1:0]         root_ext;
  logic [sfm_pkg::DEV_BITS-1:0] dev_sat;

  always_comb begin
    root_ext = EXT_BITS'(sq_root);
    dev_sat  = (root_ext > EXT_BITS'(sfm_pkg::DEV_MAX)) ? sfm_pkg::DEV_MAX
                                                         : root_ext[sfm_pkg::DEV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_tag.valid;
    end
    status    <= sq_tag.status;
    deviation <= (sq_tag.status == sfm_pkg::STATUS_OK) ? dev_sat : '0;
  end

`ifndef ASSERT_OFF
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == sfm_pkg::STATUS_OK || status == sfm_pkg::STATUS_DIV_ZERO ||
              status == sfm_pkg::STATUS_NEG_VAR))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != sfm_pkg::STATUS_OK) |-> deviation == '0)
    else $error("deviation nonzero on error");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    !$stable(sample_mode) |-> ($past(wr_en) || $past(rst)))
    else $error("sample_mode changed without write");
`endif

endmodule

FILE: rtl/sfm_div.sv
module sfm_div #(
  parameter int NUM_BITS = 119,
  parameter int DEN_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sfm_pkg::sfm_tag_t    in_tag,
  input  logic [NUM_BITS-1:0]  in_num,
  input  logic [DEN_BITS-1:0]  in_den,
  output sfm_pkg::sfm_tag_t    out_tag,
  output logic [NUM_BITS-1:0]  out_quo
);

  // stage k holds the state after k quotient bits
  sfm_pkg::sfm_tag_t   tag [0:NUM_BITS];
  logic [NUM_BITS-1:0] num [0:NUM_BITS];
  logic [NUM_BITS-1:0] quo [0:NUM_BITS];
  logic [DEN_BITS-1:0] rem [0:NUM_BITS];
  logic [DEN_BITS-1:0] den [0:NUM_BITS];

  assign tag[0] = in_tag;
  assign num[0] = in_num;
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = in_den;

  // one restoring step per stage
  for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
    logic [DEN_BITS:0]   rem_sh;
    logic                ge;
    logic [DEN_BITS:0]   rem_sub;

    always_comb begin
      rem_sh  = {rem[k], num[k][NUM_BITS-1]};
      ge      = rem_sh >= {1'b0, den[k]};
      rem_sub = rem_sh - {1'b0, den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k+1].valid <= 1'b0;
      end else begin
        tag[k+1].valid <= tag[k].valid;
      end
      tag[k+1].status <= tag[k].status;
      num[k+1]        <= num[k] << 1;
      quo[k+1]        <= {quo[k][NUM_BITS-2:0], ge};
      rem[k+1]        <= ge ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      den[k+1]        <= den[k];
    end
  end

  assign out_tag = tag[NUM_BITS];
  assign out_quo = quo[NUM_BITS];

endmodule

FILE: rtl/sfm_sqrt.sv
module sfm_sqrt #(
  parameter int ROOT_BITS = 60
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sfm_pkg::sfm_tag_t      in_tag,
  input  logic [2*ROOT_BITS-1:0] in_val,
  output sfm_pkg::sfm_tag_t      out_tag,
  output logic [ROOT_BITS-1:0]   out_root
);

  localparam int REM_BITS = ROOT_BITS + 2;

  sfm_pkg::sfm_tag_t      tag  [0:ROOT_BITS];
  logic [2*ROOT_BITS-1:0] val  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]   root [0:ROOT_BITS];
  logic [REM_BITS-1:0]    rem  [0:ROOT_BITS];

  assign tag[0]  = in_tag;
  assign val[0]  = in_val;
  assign root[0] = '0;
  assign rem[0]  = '0;

  // one root bit per stage, two radicand bits brought down
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic [REM_BITS+1:0] rem_sh;
    logic [REM_BITS+1:0] trial;
    logic                ge;
    logic [REM_BITS+1:0] rem_sub;

    always_comb begin
      rem_sh  = {rem[k], val[k][2*ROOT_BITS-1 -: 2]};
      trial   = (REM_BITS+2)'({root[k], 2'b01});
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k+1].valid <= 1'b0;
      end else begin
        tag[k+1].valid <= tag[k].valid;
      end
      tag[k+1].status <= tag[k].status;
      val[k+1]        <= val[k] << 2;
      root[k+1]       <= {root[k][ROOT_BITS-2:0], ge};
      rem[k+1]        <= ge ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    end
  end

  assign out_tag  = tag[ROOT_BITS];
  assign out_root = root[ROOT_BITS];

endmodule
